// ----- rtl/core/mte_pkg.sv -----
package mte_pkg;

  // Fixed-point one in Q16.16.
  localparam logic signed [31:0] FX_ONE = 32'sh0001_0000;

  // Command codes; codes five to seven mean nothing and are ignored.
  localparam logic [2:0] CMD_IDENTITY  = 3'd0;
  localparam logic [2:0] CMD_TRANSLATE = 3'd1;
  localparam logic [2:0] CMD_SCALE     = 3'd2;
  localparam logic [2:0] CMD_ROTATE    = 3'd3;
  localparam logic [2:0] CMD_POINT     = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] val_x;
    logic signed [31:0] val_y;
    logic signed [31:0] val_z;
    logic signed [31:0] val_w;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } res_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROTMUL,
    S_ROTSUM,
    S_RDROW,
    S_MAC,
    S_DRAIN,
    S_FIN
  } state_t;

  // Round a Q16.16 product half up: floor((p + 2^15) / 2^16).
  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return s[63:16];
  endfunction

  // Twice the product, rounded half up: floor((p + 2^14) / 2^15).
  function automatic logic signed [48:0] rnd15(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd16384;
    return s[63:15];
  endfunction

  // Saturate a wide sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sh0_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -52'sh0_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/matrix_transform_engine_top.sv -----
// Channel   Dir  Word        Handshake
// cmd       in   cmd_word_t  cmd_valid / cmd_stall
// res       out  res_word_t  res_valid / res_stall
//
// One command word is taken at a time; the block takes no new word until the
// current one is finished. The single shared 32x32 multiplier does
// one multiply-add per cycle while accumulating, and each matrix row is read
// from memory into a row buffer before its multiply-adds.
// Reset loads the identity matrix at once through per-entry valid bits.
// A stalled result sits in the output register while the next command runs; a
// following transform-point waits in its last cycle until that register frees.
module matrix_transform_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  mte_pkg::cmd_word_t cmd_word,
  output logic               res_valid,
  input  logic               res_stall,
  output mte_pkg::res_word_t res_word
);
  import mte_pkg::*;

  state_t state, state_next;

  logic [3:0]         cnt;
  logic [1:0]         row;
  logic [2:0]         cmd;
  logic signed [31:0] vx, vy, vz, vw;
  logic signed [31:0] t [16];
  logic signed [31:0] t_load [16];
  logic signed [48:0] d [9];
  logic signed [31:0] rowbuf [4];
  logic signed [31:0] resbuf [3];

  // Matrix memory with per-entry valid bits; an invalid entry reads as identity.
  logic signed [31:0] mem [16];
  logic [15:0]        vld;
  logic signed [31:0] rd_raw;
  logic               rd_hit, rd_diag;
  logic signed [31:0] rdata;
  logic [3:0]         rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic [3:0]         wr_addr;
  logic signed [31:0] wr_data;

  // Shared multiplier and its pipeline register.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               pv, p_rot;
  logic [3:0]         ptag;
  logic signed [49:0] acc;
  logic signed [49:0] acc_sum;

  logic accept;
  logic is_point;
  logic mac_last;
  logic issue;

  assign accept   = cmd_valid && !cmd_stall;
  assign is_point = (cmd == CMD_POINT);
  assign mac_last = is_point ? (cnt == 4'd3) : (cnt == 4'd15);
  assign rdata    = rd_hit ? rd_raw : (rd_diag ? FX_ONE : 32'sd0);
  assign rd_en    = (state == S_RDROW) && (cnt < 4'd4);
  assign rd_addr  = {cnt[1:0], row};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_word.command)
            CMD_TRANSLATE, CMD_SCALE, CMD_POINT: state_next = S_RDROW;
            CMD_ROTATE:                          state_next = S_ROTMUL;
            default:                             state_next = S_IDLE;
          endcase
        end
      end
      S_ROTMUL: if (cnt == 4'd9) state_next = S_ROTSUM;
      S_ROTSUM: state_next = S_RDROW;
      S_RDROW:  if (cnt == 4'd4) state_next = S_MAC;
      S_MAC:    if (mac_last) state_next = S_DRAIN;
      S_DRAIN: begin
        if (row == (is_point ? 2'd2 : 2'd3)) begin
          state_next = S_FIN;
        end else begin
          state_next = S_RDROW;
        end
      end
      S_FIN: begin
        if (!is_point || !res_valid || !res_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cmd_stall = (state != S_IDLE);
    issue     = (state == S_MAC) || ((state == S_ROTMUL) && (cnt < 4'd9));
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = rowbuf[cnt[1:0]];
    mul_b = t[cnt];
    if (state == S_ROTMUL) begin
      case (cnt)
        4'd0, 4'd3, 4'd4: mul_a = vx;
        4'd1, 4'd5:       mul_a = vy;
        4'd2:             mul_a = vz;
        default:          mul_a = vw;
      endcase
      case (cnt)
        4'd0, 4'd6:       mul_b = vx;
        4'd1, 4'd3, 4'd7: mul_b = vy;
        default:          mul_b = vz;
      endcase
    end
  end

  // Accumulate and write back.
  always_comb begin
    acc_sum = ((ptag[1:0] == 2'd0) ? 50'sd0 : acc) + 50'(rnd16(prod));
    wr_en   = pv && !p_rot && (ptag[1:0] == 2'd3) && !is_point;
    wr_addr = {ptag[3:2], row};
    wr_data = sat32(52'(acc_sum));
  end

  // Memory port: one write, one registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_raw  <= mem[rd_addr];
      rd_hit  <= vld[rd_addr];
      rd_diag <= (rd_addr[3:2] == rd_addr[1:0]);
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (accept && cmd_word.command == CMD_IDENTITY) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      row   <= '0;
      pv    <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= issue;
      case (state)
        S_IDLE:   begin cnt <= '0; row <= '0; end
        S_ROTMUL: cnt <= (cnt == 4'd9) ? 4'd0 : cnt + 4'd1;
        S_RDROW:  cnt <= (cnt == 4'd4) ? 4'd0 : cnt + 4'd1;
        S_MAC:    cnt <= mac_last ? 4'd0 : cnt + 4'd1;
        S_DRAIN:  row <= row + 2'd1;
        default:  cnt <= '0;
      endcase
    end
  end

  // Elementary matrix, or point vector, for the word at the input.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      t_load[i] = (i % 5 == 0) ? FX_ONE : 32'sd0;
    end
    case (cmd_word.command)
      CMD_TRANSLATE: begin
        t_load[12] = cmd_word.val_x;
        t_load[13] = cmd_word.val_y;
        t_load[14] = cmd_word.val_z;
      end
      CMD_SCALE: begin
        t_load[0]  = cmd_word.val_x;
        t_load[5]  = cmd_word.val_y;
        t_load[10] = cmd_word.val_z;
      end
      CMD_POINT: begin
        t_load[0] = cmd_word.val_x;
        t_load[1] = cmd_word.val_y;
        t_load[2] = cmd_word.val_z;
        t_load[3] = FX_ONE;
      end
      default: ;
    endcase
  end

  // Payload registers: command operands and elementary matrix.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_word.command;
      vx  <= cmd_word.val_x;
      vy  <= cmd_word.val_y;
      vz  <= cmd_word.val_z;
      vw  <= cmd_word.val_w;
      for (int i = 0; i < 16; i++) begin
        t[i] <= t_load[i];
      end
    end else if (state == S_ROTSUM) begin
      // Rotation elements from the doubled products xx,yy,zz,xy,xz,yz,wx,wy,wz.
      t[0]  <= sat32(52'(FX_ONE) - 52'(d[1]) - 52'(d[2]));
      t[1]  <= sat32(52'(d[3]) - 52'(d[8]));
      t[2]  <= sat32(52'(d[4]) + 52'(d[7]));
      t[4]  <= sat32(52'(d[3]) + 52'(d[8]));
      t[5]  <= sat32(52'(FX_ONE) - 52'(d[0]) - 52'(d[2]));
      t[6]  <= sat32(52'(d[5]) - 52'(d[6]));
      t[8]  <= sat32(52'(d[4]) - 52'(d[7]));
      t[9]  <= sat32(52'(d[5]) + 52'(d[6]));
      t[10] <= sat32(52'(FX_ONE) - 52'(d[0]) - 52'(d[1]));
    end
  end

  // Row buffer, multiplier stage and accumulator.
  always_ff @(posedge clk) begin
    if (state == S_RDROW && cnt != 4'd0) rowbuf[2'(cnt - 4'd1)] <= rdata;
    if (issue) begin
      prod  <= mul_a * mul_b;
      ptag  <= cnt;
      p_rot <= (state == S_ROTMUL);
    end
    if (pv && p_rot) d[ptag] <= rnd15(prod);
    if (pv && !p_rot) begin
      acc <= acc_sum;
      if (ptag[1:0] == 2'd3 && is_point && row != 2'd3) resbuf[row] <= wr_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FIN && is_point && (!res_valid || !res_stall)) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && is_point && (!res_valid || !res_stall)) begin
      res_word.out_x <= resbuf[0];
      res_word.out_y <= resbuf[1];
      res_word.out_z <= resbuf[2];
    end
  end

  // Write-back happens only while accumulating.
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_MAC || state == S_DRAIN))
    else $error("matrix write outside accumulate");

  // No write-back while a row is being read.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RDROW) |-> !wr_en)
    else $error("write during row read");

  // Load-identity clears every valid bit.
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd_word.command == CMD_IDENTITY) |=> (vld == 16'd0))
    else $error("identity did not clear matrix");

  // A result appears only at the end of a transform-point command.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_FIN && cmd == CMD_POINT))
    else $error("unexpected result word");

endmodule
